// File: rtl/core/utf8s_pkg.sv
// ----------------------------------------------------------------------------
// utf8s_pkg
// Shared widths, types and helper function for the utf-8 stream statistics
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8s_pkg;

   // counter width inside the block; reported fields are its low bits
   localparam int COUNT_WIDTH = 32;
   // width of every reported field
   localparam int FIELD_WIDTH = 32;
   // histogram bins for zero to seven leading ones
   localparam int HIST_BINS   = 8;
   // leading-one count 0..8 and pending byte count 0..8
   localparam int LEAD_WIDTH  = 4;
   localparam int PEND_WIDTH  = 4;
   localparam int VALUE_WIDTH = 32;
   localparam int BYTE_WIDTH  = 8;
   localparam int CONT_BITS   = 6;

   // all-ones byte: no histogram bin
   localparam logic [LEAD_WIDTH-1:0] LEAD_ALL_ONES = LEAD_WIDTH'(8);
   localparam logic [LEAD_WIDTH-1:0] LEAD_CONT     = LEAD_WIDTH'(1);
   localparam logic [LEAD_WIDTH-1:0] LEAD_NONE     = LEAD_WIDTH'(0);

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [LEAD_WIDTH-1:0]  lead_type;
   typedef logic [PEND_WIDTH-1:0]  pend_type;
   typedef logic [VALUE_WIDTH-1:0] value_type;

   // per-word decode result
   typedef struct packed {
      lead_type              lead;
      logic [BYTE_WIDTH-1:0] payload;
   } byte_info_type;

   // running totals
   typedef struct packed {
      count_type                 bytes;
      count_type                 ascii;
      count_type                 values;
      count_type                 sum;
      count_type [HIST_BINS-1:0] hist;
   } stats_type;

   // number of leading ones in a byte, 0 to 8
   function automatic lead_type lead_ones(input logic [BYTE_WIDTH-1:0] b);
      lead_type n;
      priority casez (b)
         8'b0???????: n = LEAD_WIDTH'(0);
         8'b10??????: n = LEAD_WIDTH'(1);
         8'b110?????: n = LEAD_WIDTH'(2);
         8'b1110????: n = LEAD_WIDTH'(3);
         8'b11110???: n = LEAD_WIDTH'(4);
         8'b111110??: n = LEAD_WIDTH'(5);
         8'b1111110?: n = LEAD_WIDTH'(6);
         8'b11111110: n = LEAD_WIDTH'(7);
         default:     n = LEAD_ALL_ONES;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/utf8s_req_if.sv
// ----------------------------------------------------------------------------
// utf8s_req_if
// Byte channel into the statistics block: one stream byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

// File: rtl/core/utf8s_rsp_if.sv
// ----------------------------------------------------------------------------
// utf8s_rsp_if
// Report channel out of the statistics block: the totals, one word per stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8s_rsp_if import utf8s_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [FIELD_WIDTH-1:0] byte_total;
   logic [FIELD_WIDTH-1:0] ascii_total;
   logic [FIELD_WIDTH-1:0] value_total;
   logic [FIELD_WIDTH-1:0] value_sum;
   logic [FIELD_WIDTH-1:0] lead_zero_count;
   logic [FIELD_WIDTH-1:0] lead_one_count;
   logic [FIELD_WIDTH-1:0] lead_two_count;
   logic [FIELD_WIDTH-1:0] lead_three_count;
   logic [FIELD_WIDTH-1:0] lead_four_count;
   logic [FIELD_WIDTH-1:0] lead_five_count;
   logic [FIELD_WIDTH-1:0] lead_six_count;
   logic [FIELD_WIDTH-1:0] lead_seven_count;

   modport source (
      output valid, output byte_total, output ascii_total, output value_total,
      output value_sum, output lead_zero_count, output lead_one_count,
      output lead_two_count, output lead_three_count, output lead_four_count,
      output lead_five_count, output lead_six_count, output lead_seven_count,
      input ready
   );
   modport sink (
      input valid, input byte_total, input ascii_total, input value_total,
      input value_sum, input lead_zero_count, input lead_one_count,
      input lead_two_count, input lead_three_count, input lead_four_count,
      input lead_five_count, input lead_six_count, input lead_seven_count,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/core/utf8s_decode.sv
// ----------------------------------------------------------------------------
// utf8s_decode
// Classifies one byte: leading-one count and the payload bits of a leader.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8s_decode import utf8s_pkg::*; (
   input  wire logic [BYTE_WIDTH-1:0] data_byte,
   output byte_info_type              info
);

   // leader payload sits below the first zero; empty for seven or eight ones
   always_comb begin
      info.lead    = lead_ones(data_byte);
      info.payload = data_byte & (8'h7f >> info.lead);
   end

endmodule

`default_nettype wire

// File: rtl/core/utf8s_accum.sv
// ----------------------------------------------------------------------------
// utf8s_accum
// Running counters, histogram and sequence decoder state. Presents the totals
// including the current word, and clears everything after a last word.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8s_accum import utf8s_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [BYTE_WIDTH-1:0] data_byte,
   input  wire logic                  end_of_file,
   input  wire byte_info_type         info,
   output stats_type                  stats_in
);

   stats_type stats_ff;
   pend_type  pend_ff;
   pend_type  pend_in;
   value_type partial_ff;
   value_type partial_in;

   pend_type  pend_start;
   logic      decoding;

   // sequence decode and totals including this word
   always_comb begin
      pend_start = pend_ff;
      if (pend_ff == '0 && info.lead >= LEAD_WIDTH'(2)) begin
         pend_start = PEND_WIDTH'(info.lead);
      end
      decoding = (info.lead != LEAD_NONE) && (pend_start != '0);

      stats_in       = stats_ff;
      pend_in        = pend_start;
      partial_in     = partial_ff;
      stats_in.bytes = stats_ff.bytes + COUNT_WIDTH'(1);
      if (info.lead == LEAD_NONE) begin
         stats_in.ascii = stats_ff.ascii + COUNT_WIDTH'(1);
      end
      for (int i = 0; i < HIST_BINS; i++) begin
         if (info.lead == LEAD_WIDTH'(i)) begin
            stats_in.hist[i] = stats_ff.hist[i] + COUNT_WIDTH'(1);
         end
      end

      if (decoding) begin
         if (info.lead == LEAD_CONT) begin
            partial_in = {partial_ff[VALUE_WIDTH-CONT_BITS-1:0], data_byte[CONT_BITS-1:0]};
         end else begin
            partial_in = VALUE_WIDTH'(info.payload);
         end
         pend_in = pend_start - PEND_WIDTH'(1);
         if (pend_in == '0) begin
            stats_in.sum    = stats_ff.sum + COUNT_WIDTH'(partial_in);
            stats_in.values = stats_ff.values + COUNT_WIDTH'(1);
         end
      end else begin
         stats_in.sum    = stats_ff.sum + COUNT_WIDTH'(data_byte);
         stats_in.values = stats_ff.values + COUNT_WIDTH'(1);
      end
   end

   // state update; a last word clears everything
   always_ff @(posedge clock) begin
      if (reset) begin
         stats_ff   <= '0;
         pend_ff    <= '0;
         partial_ff <= '0;
      end else if (accept) begin
         if (end_of_file) begin
            stats_ff   <= '0;
            pend_ff    <= '0;
            partial_ff <= '0;
         end else begin
            stats_ff   <= stats_in;
            pend_ff    <= pend_in;
            partial_ff <= partial_in;
         end
      end
   end

   // a sequence never asks for more than eight bytes
   a_pend_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PEND_WIDTH'(8))
      else $error("pending count out of range");

   // a last word leaves the state cleared
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_file) |=>
         (stats_ff.bytes == '0 && stats_ff.sum == '0 && pend_ff == '0))
      else $error("state not cleared after last word");

   // a word completes at most one value
   a_value_step: assert property (@(posedge clock) disable iff (reset)
      (accept && !end_of_file) |=>
         (stats_ff.values == $past(stats_ff.values) ||
          stats_ff.values == $past(stats_ff.values) + COUNT_WIDTH'(1)))
      else $error("value count stepped by more than one");

endmodule

`default_nettype wire

// File: rtl/core/utf8_stream_statistics_top.sv
// the report appears in the cycle after the last byte is accepted
// throughput: one byte per cycle while no report waits unread; the statistics
// update is a register-to-register path through the decoder and the counters
// a byte is refused only while a report sits in the output register unread
// reset clears all counters, the decoder state and the output valid
// ----------------------------------------------------------------------------
// utf8_stream_statistics_top
// Byte-stream statistics: counts, leading-one histogram and decoded value sum,
// reported and cleared on the last byte of each stream.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_statistics_top import utf8s_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   utf8s_req_if.sink    req_chan,
   utf8s_rsp_if.source  rsp_chan
);

   byte_info_type info;
   stats_type     stats_in;
   stats_type     rsp_stats_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          accept;

   // the output register frees itself in the cycle its word is taken
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // byte classification
   utf8s_decode u_decode (
      .data_byte (req_chan.data_byte),
      .info      (info)
   );

   // counters and sequence state
   utf8s_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_chan.data_byte),
      .end_of_file (req_chan.end_of_file),
      .info        (info),
      .stats_in    (stats_in)
   );

   // report register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (accept && req_chan.end_of_file) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_chan.end_of_file) begin
         rsp_stats_ff <= stats_in;
      end
   end

   // report fields are the low bits of each counter
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.byte_total       = FIELD_WIDTH'(rsp_stats_ff.bytes);
   assign rsp_chan.ascii_total      = FIELD_WIDTH'(rsp_stats_ff.ascii);
   assign rsp_chan.value_total      = FIELD_WIDTH'(rsp_stats_ff.values);
   assign rsp_chan.value_sum        = FIELD_WIDTH'(rsp_stats_ff.sum);
   assign rsp_chan.lead_zero_count  = FIELD_WIDTH'(rsp_stats_ff.hist[0]);
   assign rsp_chan.lead_one_count   = FIELD_WIDTH'(rsp_stats_ff.hist[1]);
   assign rsp_chan.lead_two_count   = FIELD_WIDTH'(rsp_stats_ff.hist[2]);
   assign rsp_chan.lead_three_count = FIELD_WIDTH'(rsp_stats_ff.hist[3]);
   assign rsp_chan.lead_four_count  = FIELD_WIDTH'(rsp_stats_ff.hist[4]);
   assign rsp_chan.lead_five_count  = FIELD_WIDTH'(rsp_stats_ff.hist[5]);
   assign rsp_chan.lead_six_count   = FIELD_WIDTH'(rsp_stats_ff.hist[6]);
   assign rsp_chan.lead_seven_count = FIELD_WIDTH'(rsp_stats_ff.hist[7]);

   // a last byte always produces a report next cycle
   a_report_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.end_of_file) |=> rsp_valid_ff)
      else $error("no report after last byte");

   // an ordinary byte never raises a report
   a_no_spurious_report: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_chan.end_of_file && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("report without last byte");

   // a report only appears after a last byte was taken
   a_report_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept && req_chan.end_of_file))
      else $error("report raised without cause");

endmodule

`default_nettype wire
